FILE: rtl/copf_pkg.sv
// Package for the cascaded one-pole resonant filter.
// Holds field widths, register indexes, reset values, the controller/datapath
// command and status structs and the saturation helpers. No dependencies.
package copf_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned STAGE_W    = 32;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned KR_W       = 18;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned MUL_COEF_W = 19;
  localparam int unsigned MUL_OP_W   = 34;
  localparam int unsigned PROD_W     = 53;
  localparam int unsigned ACC_W      = 38;

  localparam int unsigned NUM_STAGES_DEF   = 4;
  localparam int unsigned NUM_CHANNELS_DEF = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_COEFF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE_GAIN = 2'd2;

  localparam logic MODE_LOWPASS  = 1'b0;
  localparam logic MODE_HIGHPASS = 1'b1;

  localparam logic [COEF_W-1:0] CUTOFF_RESET    = 16'h8000;
  localparam logic [COEF_W-1:0] RESONANCE_RESET = 16'h0000;
  localparam logic [COEF_W:0]   UNITY_Q16       = 17'h10000;

  typedef struct packed {
    logic take_in;
    logic rd_first;
    logic ld_first;
    logic mul_a;
    logic mul_b;
    logic write_back;
    logic out_load;
  } copf_cmd_t;

  typedef struct packed {
    logic last_stage;
    logic out_free;
  } copf_sts_t;

  function automatic logic signed [STAGE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [STAGE_W-1:0] r;
    if ((v[ACC_W-1:STAGE_W-1] == '0) || (v[ACC_W-1:STAGE_W-1] == '1)) begin
      r = v[STAGE_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(STAGE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(STAGE_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [STAGE_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if ((v[STAGE_W-1:SAMPLE_W-1] == '0) || (v[STAGE_W-1:SAMPLE_W-1] == '1)) begin
      r = v[SAMPLE_W-1:0];
    end else if (v[STAGE_W-1]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: rtl/cascaded_one_pole_resonant_filter.sv
// Top level of the cascaded one-pole resonant filter.
// Holds the configuration registers and the k*r product, and joins copf_ctrl
// and copf_dp. Depends on copf_pkg, copf_ctrl and copf_dp.
//
// Usage: each request on the s_axis channel carries one signed 24-bit sample
// and a channel number. The sample runs through NUM_STAGES one-pole stages of
// that channel, lowest stage first, and one request on m_axis returns the new
// last-stage value saturated to 24 bits together with the channel.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while no
// request is in flight: index 0 selects lowpass or highpass, 1 sets k, 2 sets r.
// Flow: after acceptance the controller reads the first stage values, runs
// each stage in turn and loads the result into the output register in the
// final state; a new item is accepted only once the controller is back in
// idle after that load. Each stage needs two products on the one shared
// multiplier and a write-back to the stage memory.
// Reset clears all stage values and previous inputs and sets lowpass, k=0.5,
// r=0. When the receiver stalls, the result waits in the output register; the
// next item is still accepted and computed and then waits in the final state
// until the register is free.
module cascaded_one_pole_resonant_filter #(
  parameter int unsigned NUM_STAGES   = copf_pkg::NUM_STAGES_DEF,
  parameter int unsigned NUM_CHANNELS = copf_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [copf_pkg::SAMPLE_W-1:0]       s_axis_tdata,   // [23:0] sample_in
  input  logic [0:0]                          s_axis_tuser,   // [0] channel_in
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [copf_pkg::SAMPLE_W-1:0]       m_axis_tdata,   // [23:0] sample_out
  output logic [0:0]                          m_axis_tuser,   // [0] channel_out
  input  logic                                cfg_we_i,
  input  logic [copf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [copf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic                          mode_q, mode_d;
  logic [copf_pkg::COEF_W-1:0]   cutoff_q, cutoff_d;
  logic [copf_pkg::COEF_W-1:0]   res_q, res_d;
  logic [copf_pkg::KR_W-1:0]     kr_q;
  logic [31:0]                   kr_sum;

  copf_pkg::copf_cmd_t cmd;
  copf_pkg::copf_sts_t sts;

  logic signed [copf_pkg::SAMPLE_W-1:0] sample_out;
  logic                                 channel_out;

  always_comb begin
    mode_d   = mode_q;
    cutoff_d = cutoff_q;
    res_d    = res_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        copf_pkg::CFG_FILTER_MODE:    mode_d   = cfg_data_i[0];
        copf_pkg::CFG_CUTOFF_COEFF:   cutoff_d = cfg_data_i;
        copf_pkg::CFG_RESONANCE_GAIN: res_d    = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign kr_sum = cutoff_q * res_q + 32'd8192;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= copf_pkg::MODE_LOWPASS;
      cutoff_q <= copf_pkg::CUTOFF_RESET;
      res_q    <= copf_pkg::RESONANCE_RESET;
      kr_q     <= '0;
    end else begin
      mode_q   <= mode_d;
      cutoff_q <= cutoff_d;
      res_q    <= res_d;
      kr_q     <= kr_sum[31:14];
    end
  end

  copf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  copf_dp #(
    .NUM_STAGES   (NUM_STAGES),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .filter_mode_i  (mode_q),
    .cutoff_coeff_i (cutoff_q),
    .kr_i           (kr_q),
    .sample_in_i    (s_axis_tdata),
    .channel_in_i   (s_axis_tuser[0]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .sample_out_o   (sample_out),
    .channel_out_o  (channel_out)
  );

  assign m_axis_tdata    = sample_out;
  assign m_axis_tuser[0] = channel_out;

endmodule

FILE: rtl/copf_ctrl.sv
// Sequencing state machine of the cascaded one-pole resonant filter.
// Drives the datapath through copf_pkg::copf_cmd_t and reads copf_pkg::copf_sts_t.
// Depends on copf_pkg.
module copf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  copf_pkg::copf_sts_t sts_i,
  output copf_pkg::copf_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD0  = 7'b0000010,
    S_LD0  = 7'b0000100,
    S_MUL1 = 7'b0001000,
    S_MUL2 = 7'b0010000,
    S_WB   = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = S_RD0;
        end
      end
      S_RD0: begin
        cmd_o.rd_first = 1'b1;
        state_d        = S_LD0;
      end
      S_LD0: begin
        cmd_o.ld_first = 1'b1;
        state_d        = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_a = 1'b1;
        state_d     = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_b = 1'b1;
        state_d     = S_WB;
      end
      S_WB: begin
        cmd_o.write_back = 1'b1;
        state_d          = sts_i.last_stage ? S_FIN : S_MUL1;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_wb_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && sts_i.last_stage) |=> (state_q == S_FIN))
    else $error("last write-back not followed by the final state");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("output register loaded while still occupied");
`endif

endmodule

FILE: rtl/copf_dp.sv
// Datapath of the cascaded one-pole resonant filter: stage memory with valid
// bits, previous-input registers, one shared multiplier, rounding, saturation
// and the output register. Depends on copf_pkg.
module copf_dp #(
  parameter int unsigned NUM_STAGES   = copf_pkg::NUM_STAGES_DEF,
  parameter int unsigned NUM_CHANNELS = copf_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  copf_pkg::copf_cmd_t                    cmd_i,
  output copf_pkg::copf_sts_t                    sts_o,
  input  logic                                   filter_mode_i,
  input  logic [copf_pkg::COEF_W-1:0]            cutoff_coeff_i,
  input  logic [copf_pkg::KR_W-1:0]              kr_i,
  input  logic signed [copf_pkg::SAMPLE_W-1:0]   sample_in_i,
  input  logic                                   channel_in_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic signed [copf_pkg::SAMPLE_W-1:0]   sample_out_o,
  output logic                                   channel_out_o
);

  localparam int unsigned DEPTH = NUM_STAGES * NUM_CHANNELS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int unsigned CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [SW:0] LAST  = (SW+1)'(NUM_STAGES - 1);

  localparam int unsigned SAMPLE_W   = copf_pkg::SAMPLE_W;
  localparam int unsigned STAGE_W    = copf_pkg::STAGE_W;
  localparam int unsigned MUL_COEF_W = copf_pkg::MUL_COEF_W;
  localparam int unsigned MUL_OP_W   = copf_pkg::MUL_OP_W;
  localparam int unsigned PROD_W     = copf_pkg::PROD_W;
  localparam int unsigned ACC_W      = copf_pkg::ACC_W;

  logic signed [SAMPLE_W-1:0] x_q;
  logic [CW-1:0]              ch_q;
  logic [SW-1:0]              stage_q;

  logic signed [STAGE_W-1:0]  stage_mem_q [DEPTH];
  logic [DEPTH-1:0]           vld_q;
  logic signed [STAGE_W-1:0]  rd_data_q;
  logic                       rd_vld_q;
  logic signed [SAMPLE_W-1:0] prev_in_q [NUM_CHANNELS];

  logic signed [STAGE_W-1:0]  cur_q, nxt_q, pnew_q, pold_q;
  logic signed [PROD_W-1:0]   prod_a_q, prod_b_q;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_chan_q;

  logic [SW:0]                rd_want;
  logic [SW-1:0]              rd_stage;
  logic                       rd_en;
  logic [AW-1:0]              base_addr, rd_addr, wr_addr;
  logic signed [STAGE_W-1:0]  rd_val;

  logic signed [MUL_COEF_W-1:0] mul_coef;
  logic signed [MUL_OP_W-1:0]   mul_op;
  logic signed [PROD_W-1:0]     mul_p;
  logic signed [MUL_OP_W-1:0]   cur_x, nxt_x, pnew_x, pold_x;

  logic signed [PROD_W-1:0]   acc_sum;
  logic signed [PROD_W-1:0]   acc_rnd;
  logic signed [ACC_W-1:0]    acc_pre;
  logic signed [STAGE_W-1:0]  new_val;
  logic                       last_stage;
  logic [CW-1:0]              ch_d;

  assign ch_d = (NUM_CHANNELS > 1) ? CW'(channel_in_i) : '0;

  assign last_stage       = (stage_q == LAST[SW-1:0]);
  assign sts_o.last_stage = last_stage;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    if (cmd_i.rd_first) begin
      rd_want = '0;
    end else if (cmd_i.ld_first) begin
      rd_want = (SW+1)'(1);
    end else begin
      rd_want = {1'b0, stage_q} + (SW+1)'(2);
    end
  end

  assign rd_stage  = (rd_want > LAST) ? LAST[SW-1:0] : rd_want[SW-1:0];
  assign rd_en     = cmd_i.rd_first || cmd_i.ld_first || cmd_i.write_back;
  assign base_addr = AW'(ch_q) * AW'(NUM_STAGES);
  assign rd_addr   = base_addr + AW'(rd_stage);
  assign wr_addr   = base_addr + AW'(stage_q);
  assign rd_val    = rd_vld_q ? rd_data_q : '0;

  assign cur_x  = MUL_OP_W'(cur_q);
  assign nxt_x  = MUL_OP_W'(nxt_q);
  assign pnew_x = MUL_OP_W'(pnew_q);
  assign pold_x = MUL_OP_W'(pold_q);

  always_comb begin
    if (cmd_i.mul_a) begin
      if (filter_mode_i == copf_pkg::MODE_LOWPASS) begin
        mul_coef = MUL_COEF_W'({1'b0, cutoff_coeff_i});
        mul_op   = pnew_x - cur_x;
      end else begin
        mul_coef = MUL_COEF_W'(copf_pkg::UNITY_Q16 - {1'b0, cutoff_coeff_i});
        mul_op   = cur_x + pnew_x - pold_x;
      end
    end else begin
      mul_coef = MUL_COEF_W'({1'b0, kr_i});
      if (filter_mode_i == copf_pkg::MODE_LOWPASS) begin
        mul_op = cur_x - nxt_x;
      end else begin
        mul_op = nxt_x - cur_x;
      end
    end
  end

  assign mul_p = mul_coef * mul_op;

  assign acc_sum = prod_a_q + prod_b_q;
  assign acc_rnd = acc_sum + PROD_W'(32768);
  always_comb begin
    if (filter_mode_i == copf_pkg::MODE_LOWPASS) begin
      acc_pre = ACC_W'($signed(acc_rnd[PROD_W-1:16])) + ACC_W'(cur_q);
    end else begin
      acc_pre = ACC_W'($signed(acc_rnd[PROD_W-1:16]));
    end
  end
  assign new_val = copf_pkg::sat32(acc_pre);

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_back) begin
      stage_mem_q[wr_addr] <= new_val;
    end
    if (rd_en) begin
      rd_data_q <= stage_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
        prev_in_q[i] <= '0;
      end
    end else begin
      if (cmd_i.write_back) begin
        vld_q[wr_addr] <= 1'b1;
        if (last_stage && filter_mode_i == copf_pkg::MODE_HIGHPASS) begin
          prev_in_q[ch_q] <= x_q;
        end
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      ch_q    <= '0;
    end else begin
      if (cmd_i.take_in) begin
        stage_q <= '0;
        ch_q    <= ch_d;
      end else if (cmd_i.write_back && !last_stage) begin
        stage_q <= stage_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      x_q <= sample_in_i;
    end
    if (cmd_i.ld_first) begin
      cur_q  <= rd_val;
      pnew_q <= STAGE_W'(x_q);
      pold_q <= STAGE_W'(prev_in_q[ch_q]);
    end
    if (cmd_i.mul_a) begin
      nxt_q    <= rd_val;
      prod_a_q <= mul_p;
    end
    if (cmd_i.mul_b) begin
      prod_b_q <= last_stage ? '0 : mul_p;
    end
    if (cmd_i.write_back) begin
      pold_q <= cur_q;
      pnew_q <= new_val;
      cur_q  <= nxt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_sample_q <= copf_pkg::sat24(pnew_q);
      out_chan_q   <= ch_q[0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_sample_q;
  assign channel_out_o = out_chan_q;

`ifndef NO_ASSERTIONS
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("result not presented after output load");

  a_stage_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.write_back && !last_stage) |=> (stage_q == SW'($past(stage_q) + SW'(1))))
    else $error("stage counter did not advance after write-back");
`endif

endmodule

FILE: verif/copf_checker.sv
// Checker for the cascaded one-pole resonant filter: watches the configuration port
// and both stream channels, predicts each filtered sample and compares it on output.
// Depends on copf_pkg.
module copf_checker #(
  parameter int unsigned NUM_STAGES   = copf_pkg::NUM_STAGES_DEF,
  parameter int unsigned NUM_CHANNELS = copf_pkg::NUM_CHANNELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [copf_pkg::SAMPLE_W-1:0]      s_axis_tdata,
  input  logic [0:0]                         s_axis_tuser,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [copf_pkg::SAMPLE_W-1:0]      m_axis_tdata,
  input  logic [0:0]                         m_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic [copf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [copf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output int                                 errors_o,
  output int                                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import copf_pkg::*;

  localparam longint ROUND_Q16 = 64'sd32768;
  localparam longint ROUND_Q14 = 64'sd8192;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [0:0]                 channel;
  } filt_result_t;

  logic signed [STAGE_W-1:0]  stage_mem [NUM_CHANNELS][NUM_STAGES];
  logic signed [SAMPLE_W-1:0] last_input [NUM_CHANNELS];
  logic                       mode_q;
  logic [COEF_W-1:0]          cutoff_q;
  logic [COEF_W-1:0]          reso_q;
  filt_result_t               expected_samples [$];
  filt_result_t               got;
  filt_result_t               want;

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic filt_result_t run_cascade(input logic signed [SAMPLE_W-1:0] x_in,
                                               input logic [0:0] ch_in);
    int unsigned  ch;
    int           i;
    longint       x, k, kr, acc, s, below_new, below_old, above;
    filt_result_t res;
    ch = int'(ch_in) % NUM_CHANNELS;
    x = longint'(x_in);
    k = longint'(cutoff_q);
    kr = (longint'(cutoff_q) * longint'(reso_q) + ROUND_Q14) >>> 14;
    below_old = longint'(last_input[ch]);
    for (i = 0; i < NUM_STAGES; i++) begin
      s = longint'(stage_mem[ch][i]);
      if (i == 0) begin
        below_new = x;
      end else begin
        below_new = longint'(stage_mem[ch][i-1]);
      end
      if (i < NUM_STAGES - 1) begin
        above = longint'(stage_mem[ch][i+1]);
      end else begin
        above = 0;
      end
      if (mode_q == MODE_LOWPASS) begin
        acc = k * (below_new - s);
        if (i < NUM_STAGES - 1) acc += kr * (s - above);
        stage_mem[ch][i] = STAGE_W'(clamp(s + ((acc + ROUND_Q16) >>> 16), STAGE_W));
      end else begin
        acc = (longint'(UNITY_Q16) - k) * (s + below_new - below_old);
        if (i < NUM_STAGES - 1) acc += kr * (above - s);
        stage_mem[ch][i] = STAGE_W'(clamp((acc + ROUND_Q16) >>> 16, STAGE_W));
        below_old = s;
      end
    end
    if (mode_q == MODE_HIGHPASS) last_input[ch] = x_in;
    res.sample  = SAMPLE_W'(clamp(longint'(stage_mem[ch][NUM_STAGES-1]), SAMPLE_W));
    res.channel = ch[0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        last_input[c] = '0;
        for (int st = 0; st < NUM_STAGES; st++) stage_mem[c][st] = '0;
      end
      mode_q   = MODE_LOWPASS;
      cutoff_q = CUTOFF_RESET;
      reso_q   = RESONANCE_RESET;
      expected_samples.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FILTER_MODE:    mode_q = cfg_data_i[0];
          CFG_CUTOFF_COEFF:   cutoff_q = cfg_data_i[COEF_W-1:0];
          CFG_RESONANCE_GAIN: reso_q = cfg_data_i[COEF_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.sample  = m_axis_tdata;
        got.channel = m_axis_tuser;
        if (expected_samples.size() == 0) begin
          $display("%0t unexpected result: sample %0d channel %0d", $time, got.sample,
                   got.channel);
          errors_o++;
        end else begin
          want = expected_samples.pop_front();
          if (got.sample !== want.sample) begin
            $display("%0t sample_out mismatch: expected %0d, actual %0d", $time,
                     want.sample, got.sample);
            errors_o++;
          end
          if (got.channel !== want.channel) begin
            $display("%0t channel_out mismatch: expected %0d, actual %0d", $time,
                     want.channel, got.channel);
            errors_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_samples.push_back(run_cascade(s_axis_tdata, s_axis_tuser));
      end
      pending_o = expected_samples.size();
    end
  end

endmodule

FILE: verif/testbench.sv
// Top of the testbench for the cascaded one-pole resonant filter: clock, reset,
// register writes, sample stimulus with bursts and back-pressure, and the verdict.
// Depends on copf_pkg, cascaded_one_pole_resonant_filter and copf_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import copf_pkg::*;

  localparam logic [CFG_IDX_W-1:0]   CFG_IDX_SPARE = 2'd3;
  localparam logic [SAMPLE_W-1:0]    SAMPLE_MAX    = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0]    SAMPLE_MIN    = 24'h800000;
  localparam logic [SAMPLE_W-1:0]    SAMPLE_NEG1   = 24'hFFFFFF;
  localparam int                     NUM_PHASES    = 12;
  localparam int                     PHASE_ITEMS   = 90;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [SAMPLE_W-1:0]    s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]    m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  int                     errors;
  int                     pending;
  int                     burst_left = 0;
  int                     stall_left = 0;
  int                     stall_style = 0;
  logic [SAMPLE_W-1:0]    held_sample = '0;

  cascaded_one_pole_resonant_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  copf_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(5, 200);
    end
    stall_left--;
    case (stall_style)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 15) == 0);
      default: m_axis_tready <= ~m_axis_tready;
    endcase
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [0:0] ch);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: held_sample = SAMPLE_MAX;
      1: held_sample = SAMPLE_MIN;
      2: held_sample = SAMPLE_W'($urandom_range(0, 511)) - 24'd256;
      3, 4: ;
      default: held_sample = SAMPLE_W'($urandom);
    endcase
    return held_sample;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_cutoff();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 2047));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_resonance();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int phase;
    int n;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_NEG1, 1'b1);

    wait_idle();
    write_reg(CFG_FILTER_MODE, 16'h0001);
    write_reg(CFG_CUTOFF_COEFF, 16'h0000);
    write_reg(CFG_RESONANCE_GAIN, 16'hFFFF);
    repeat (3) send_sample(SAMPLE_MAX, 1'b0);
    repeat (2) send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);

    wait_idle();
    write_reg(CFG_FILTER_MODE, 16'hFFFE);
    write_reg(CFG_CUTOFF_COEFF, 16'hFFFF);
    repeat (3) send_sample(SAMPLE_MAX, 1'b0);
    repeat (3) send_sample(SAMPLE_MIN, 1'b1);

    wait_idle();
    write_reg(CFG_FILTER_MODE, 16'h0001);
    write_reg(CFG_RESONANCE_GAIN, 16'h0000);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_NEG1, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);

    wait_idle();
    write_reg(CFG_IDX_SPARE, 16'hFFFF);
    send_sample(SAMPLE_MAX, 1'b0);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      write_reg(CFG_FILTER_MODE, 16'($urandom));
      write_reg(CFG_CUTOFF_COEFF, pick_cutoff());
      write_reg(CFG_RESONANCE_GAIN, pick_resonance());
      if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_SPARE, 16'($urandom));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(pick_sample(), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 199) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
rtl/copf_pkg.sv
rtl/copf_ctrl.sv
rtl/copf_dp.sv
rtl/cascaded_one_pole_resonant_filter.sv
verif/copf_checker.sv
verif/testbench.sv
